FILE: design/sj_pkg.sv
// shared types, constants and the f table of the skipjack pipeline
package sj_pkg;

  localparam int SJ_ROUNDS   = 32;
  localparam int SJ_RULE_LEN = 8;
  localparam int SJ_KEY_LEN  = 10;
  localparam int SJ_STAGES   = 2 * SJ_ROUNDS;
  localparam int KEY_W       = 8 * SJ_KEY_LEN;

  // configuration register indexes
  localparam logic CFG_KEY_LO = 1'b0;
  localparam logic CFG_KEY_HI = 1'b1;

  // direction codes
  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] blk;
    logic [15:0] mid;
  } sj_item_t;

  localparam logic [7:0] SJ_F_TABLE [256] = '{
    8'ha3, 8'hd7, 8'h09, 8'h83, 8'hf8, 8'h48, 8'hf6, 8'hf4,
    8'hb3, 8'h21, 8'h15, 8'h78, 8'h99, 8'hb1, 8'haf, 8'hf9,
    8'he7, 8'h2d, 8'h4d, 8'h8a, 8'hce, 8'h4c, 8'hca, 8'h2e,
    8'h52, 8'h95, 8'hd9, 8'h1e, 8'h4e, 8'h38, 8'h44, 8'h28,
    8'h0a, 8'hdf, 8'h02, 8'ha0, 8'h17, 8'hf1, 8'h60, 8'h68,
    8'h12, 8'hb7, 8'h7a, 8'hc3, 8'he9, 8'hfa, 8'h3d, 8'h53,
    8'h96, 8'h84, 8'h6b, 8'hba, 8'hf2, 8'h63, 8'h9a, 8'h19,
    8'h7c, 8'hae, 8'he5, 8'hf5, 8'hf7, 8'h16, 8'h6a, 8'ha2,
    8'h39, 8'hb6, 8'h7b, 8'h0f, 8'hc1, 8'h93, 8'h81, 8'h1b,
    8'hee, 8'hb4, 8'h1a, 8'hea, 8'hd0, 8'h91, 8'h2f, 8'hb8,
    8'h55, 8'hb9, 8'hda, 8'h85, 8'h3f, 8'h41, 8'hbf, 8'he0,
    8'h5a, 8'h58, 8'h80, 8'h5f, 8'h66, 8'h0b, 8'hd8, 8'h90,
    8'h35, 8'hd5, 8'hc0, 8'ha7, 8'h33, 8'h06, 8'h65, 8'h69,
    8'h45, 8'h00, 8'h94, 8'h56, 8'h6d, 8'h98, 8'h9b, 8'h76,
    8'h97, 8'hfc, 8'hb2, 8'hc2, 8'hb0, 8'hfe, 8'hdb, 8'h20,
    8'he1, 8'heb, 8'hd6, 8'he4, 8'hdd, 8'h47, 8'h4a, 8'h1d,
    8'h42, 8'hed, 8'h9e, 8'h6e, 8'h49, 8'h3c, 8'hcd, 8'h43,
    8'h27, 8'hd2, 8'h07, 8'hd4, 8'hde, 8'hc7, 8'h67, 8'h18,
    8'h89, 8'hcb, 8'h30, 8'h1f, 8'h8d, 8'hc6, 8'h8f, 8'haa,
    8'hc8, 8'h74, 8'hdc, 8'hc9, 8'h5d, 8'h5c, 8'h31, 8'ha4,
    8'h70, 8'h88, 8'h61, 8'h2c, 8'h9f, 8'h0d, 8'h2b, 8'h87,
    8'h50, 8'h82, 8'h54, 8'h64, 8'h26, 8'h7d, 8'h03, 8'h40,
    8'h34, 8'h4b, 8'h1c, 8'h73, 8'hd1, 8'hc4, 8'hfd, 8'h3b,
    8'hcc, 8'hfb, 8'h7f, 8'hab, 8'he6, 8'h3e, 8'h5b, 8'ha5,
    8'had, 8'h04, 8'h23, 8'h9c, 8'h14, 8'h51, 8'h22, 8'hf0,
    8'h29, 8'h79, 8'h71, 8'h7e, 8'hff, 8'h8c, 8'h0e, 8'he2,
    8'h0c, 8'hef, 8'hbc, 8'h72, 8'h75, 8'h6f, 8'h37, 8'ha1,
    8'hec, 8'hd3, 8'h8e, 8'h62, 8'h8b, 8'h86, 8'h10, 8'he8,
    8'h08, 8'h77, 8'h11, 8'hbe, 8'h92, 8'h4f, 8'h24, 8'hc5,
    8'h32, 8'h36, 8'h9d, 8'hcf, 8'hf3, 8'ha6, 8'hbb, 8'hac,
    8'h5e, 8'h6c, 8'ha9, 8'h13, 8'h57, 8'h25, 8'hb5, 8'he3,
    8'hbd, 8'ha8, 8'h3a, 8'h01, 8'h05, 8'h59, 8'h2a, 8'h46
  };

  function automatic logic [7:0] sj_f(input logic [7:0] x);
    return SJ_F_TABLE[x];
  endfunction

endpackage

FILE: design/sj_stage.sv
// one pipeline stage: half of a g permutation, and the round rule on the second half
module sj_stage #(
  parameter int STAGE_IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic [sj_pkg::KEY_W-1:0] key,
  input  logic                     in_valid,
  input  sj_pkg::sj_item_t         in_item,
  output logic                     valid_r,
  output sj_pkg::sj_item_t         item_r
);
  import sj_pkg::*;

  localparam int RND_IDX = STAGE_IDX / 2;
  localparam bit SECOND  = (STAGE_IDX % 2) == 1;
  localparam int RE      = RND_IDX + 1;
  localparam int RD      = SJ_ROUNDS - RND_IDX;
  localparam int SE      = 4 * (RE - 1);
  localparam int SD      = 4 * (RD - 1);
  localparam int KE_X    = SECOND ? (SE + 2) % SJ_KEY_LEN : SE % SJ_KEY_LEN;
  localparam int KE_Y    = SECOND ? (SE + 3) % SJ_KEY_LEN : (SE + 1) % SJ_KEY_LEN;
  localparam int KD_X    = SECOND ? (SD + 1) % SJ_KEY_LEN : (SD + 3) % SJ_KEY_LEN;
  localparam int KD_Y    = SECOND ? SD % SJ_KEY_LEN : (SD + 2) % SJ_KEY_LEN;
  localparam bit RULE_A_E = (((RE - 1) / SJ_RULE_LEN) % 2) == 0;
  localparam bit RULE_A_D = (((RD - 1) / SJ_RULE_LEN) % 2) == 0;
  localparam logic [15:0] RE_W = 16'(RE);
  localparam logic [15:0] RD_W = 16'(RD);

  logic [7:0]  ke_x, ke_y, kd_x, kd_y;
  logic [15:0] w0, w1, w2, w3;
  logic [15:0] src_e, src_d;
  logic [7:0]  e_p, e_q, d_p, d_q;
  logic [15:0] t_e, t_d;
  sj_item_t    item_nxt;

  assign ke_x = key[KEY_W-1-8*KE_X -: 8];
  assign ke_y = key[KEY_W-1-8*KE_Y -: 8];
  assign kd_x = key[KEY_W-1-8*KD_X -: 8];
  assign kd_y = key[KEY_W-1-8*KD_Y -: 8];

  assign w0 = in_item.blk[63:48];
  assign w1 = in_item.blk[47:32];
  assign w2 = in_item.blk[31:16];
  assign w3 = in_item.blk[15:0];

  // first half starts from the word itself, second half from the stored midpoint
  assign src_e = SECOND ? in_item.mid : w0;
  assign src_d = SECOND ? in_item.mid : w1;

  // forward feistel steps: p = hi ^ f(lo ^ kx), q = lo ^ f(p ^ ky)
  assign e_p = src_e[15:8] ^ sj_f(src_e[7:0] ^ ke_x);
  assign e_q = src_e[7:0] ^ sj_f(e_p ^ ke_y);
  assign t_e = {e_p, e_q};

  // inverse feistel steps run on (hi, lo) swapped
  assign d_p = src_d[7:0] ^ sj_f(src_d[15:8] ^ kd_x);
  assign d_q = src_d[15:8] ^ sj_f(d_p ^ kd_y);
  assign t_d = {d_q, d_p};

  always_comb begin
    item_nxt     = in_item;
    if (!SECOND) begin
      item_nxt.mid = (in_item.cmd == CMD_ENC) ? t_e : t_d;
    end else if (in_item.cmd == CMD_ENC) begin
      if (RULE_A_E) begin
        item_nxt.blk = {t_e ^ w3 ^ RE_W, t_e, w1, w2};
      end else begin
        item_nxt.blk = {w3, t_e, w0 ^ w1 ^ RE_W, w2};
      end
    end else begin
      if (RULE_A_D) begin
        item_nxt.blk = {t_d, w2, w3, w0 ^ w1 ^ RD_W};
      end else begin
        item_nxt.blk = {t_d, t_d ^ w2 ^ RD_W, w3, w0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: design/sj_key_regs.sv
// key configuration registers
module sj_key_regs (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_addr,
  input  logic [63:0]              cfg_wdata,
  output logic [sj_pkg::KEY_W-1:0] key
);
  import sj_pkg::*;

  logic [63:0] key_lo_r;
  logic [15:0] key_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0;
      key_hi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEY_LO: key_lo_r <= cfg_wdata;
        CFG_KEY_HI: key_hi_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign key = {key_lo_r, key_hi_r};

endmodule

FILE: design/skipjack_block_cipher.sv
// skipjack block cipher top level: 64-stage pipeline, half a round per stage
//
//  channel | dir | handshake           | payload
//  in      | in  | in_tvalid/in_tready | in_tuser: cmd, in_tdata: block_in
//  out     | out | out_tvalid/tready   | out_tdata: block_out
//  cfg     | in  | cfg_we              | cfg_addr, cfg_wdata (key registers)
//
// one block per cycle while the output is not stalled; two stages per round
// (two f lookups each), 32 rounds. rst_n clears all stage valid bits and
// the key. a stalled output freezes every stage, bubbles included, so no
// request is lost or repeated; in_tready follows !out_tvalid || out_tready.
module skipjack_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // block_in
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // block_out
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata
);
  import sj_pkg::*;

  logic [KEY_W-1:0] key;
  logic             en;
  sj_item_t         in_item;
  logic             stage_valid [SJ_STAGES];
  sj_item_t         stage_item  [SJ_STAGES];

  sj_key_regs u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .key       (key)
  );

  assign en         = !stage_valid[SJ_STAGES-1] || out_tready;
  assign in_tready  = en;
  assign in_item    = '{cmd: in_tuser, blk: in_tdata, mid: 16'h0000};
  assign out_tvalid = stage_valid[SJ_STAGES-1];
  assign out_tdata  = stage_item[SJ_STAGES-1].blk;

  for (genvar i = 0; i < SJ_STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      sj_stage #(.STAGE_IDX(i)) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .key      (key),
        .in_valid (in_tvalid),
        .in_item  (in_item),
        .valid_r  (stage_valid[i]),
        .item_r   (stage_item[i])
      );
    end else begin : g_rest
      sj_stage #(.STAGE_IDX(i)) u_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .key      (key),
        .in_valid (stage_valid[i-1]),
        .in_item  (stage_item[i-1]),
        .valid_r  (stage_valid[i]),
        .item_r   (stage_item[i])
      );
    end
  end

  // an accepted request lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> stage_valid[0])
    else $error("accepted request missing from first stage");

  // a stall holds the middle and last stages
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> ($stable(stage_valid[SJ_STAGES/2]) && $stable(out_tvalid)))
    else $error("pipeline moved during stall");

  // back pressure only comes from a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a waiting result");

endmodule
